// ===== hdl/urx_pkg.sv =====
// Shared types and constants for the UART receive FIFO with line notify.
`default_nettype none
package urx_pkg;

  localparam int unsigned DepthDefault = 32;
  localparam int unsigned FillWidth    = 6;
  localparam int unsigned ApbAddrWidth = 3;

  localparam logic [7:0] LineFeed = 8'h0A;

  localparam logic FuncRx   = 1'b0;
  localparam logic FuncRead = 1'b1;

  localparam logic RegLineMode = 1'b0;
  localparam logic RegIgnoreLf = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 notify;
    logic                 read_valid;
    logic [7:0]           read_byte;
    logic [FillWidth-1:0] fill_count;
    logic                 paused;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/urx_mem.sv =====
// Byte store: one write port, one read port, registered read data.
`default_nettype none
module urx_mem #(
  parameter int unsigned DEPTH = urx_pkg::DepthDefault,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/uart_rx_fifo_line_notify.sv =====
// Top level: UART receive ring buffer with flow-control pause and notify.
// The result is strobed in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle; busy stays low and the receiver cannot stall.
// The byte store is a synchronous RAM with registered read data; pointers and fill live in flops.
// Reset clears pointers, fill and pause; line_mode resets to 1, ignore_line_feed to 0.
// Store contents are undefined after reset and are only read once written.
`default_nettype none
module uart_rx_fifo_line_notify #(
  parameter int unsigned DEPTH = urx_pkg::DepthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire urx_pkg::item_t                    item_i,
  output logic                                   valid_o,
  output urx_pkg::result_t                       result_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [urx_pkg::ApbAddrWidth-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PtrLast  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CntFull  = CW'(DEPTH);
  localparam logic [CW-1:0] CntLast  = CW'(DEPTH - 1);
  localparam logic [CW-1:0] CntHalf  = CW'(DEPTH / 2);
  localparam logic [CW-1:0] CntOne   = CW'(1);

  logic          line_mode_q, ign_lf_q;
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          paused_q, paused_d;
  logic          valid_q;
  logic          acc_q, acc_d, ntf_q, ntf_d, rvld_q, rvld_d;
  logic          accept, mem_we, mem_re;
  logic [7:0]    rdata;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == urx_pkg::RegIgnoreLf) ? {31'b0, ign_lf_q}
                                                     : {31'b0, line_mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode_q <= 1'b1;
      ign_lf_q    <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == urx_pkg::RegLineMode) begin
        line_mode_q <= pwdata[0];
      end else begin
        ign_lf_q <= pwdata[0];
      end
    end
  end

  // transaction processing
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    wptr_d   = wptr_q;
    rptr_d   = rptr_q;
    cnt_d    = cnt_q;
    paused_d = paused_q;
    acc_d    = 1'b0;
    ntf_d    = 1'b0;
    rvld_d   = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    if (accept) begin
      if (item_i.func == urx_pkg::FuncRx) begin
        if (paused_q) begin
          paused_d = paused_q;
        end else if (cnt_q >= CntFull) begin
          paused_d = 1'b1;
          ntf_d    = line_mode_q;
        end else begin
          mem_we = 1'b1;
          acc_d  = 1'b1;
          wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + AW'(1);
          cnt_d  = cnt_q + CntOne;
          if (line_mode_q) begin
            ntf_d = !ign_lf_q && (item_i.rx_byte == urx_pkg::LineFeed || cnt_q == CntLast);
          end else begin
            ntf_d = (cnt_d <= CntOne) || (cnt_d > CntHalf);
          end
        end
      end else if (cnt_q != '0) begin
        mem_re = 1'b1;
        rvld_d = 1'b1;
        rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + AW'(1);
        cnt_d  = cnt_q - CntOne;
        if (cnt_d == '0) begin
          paused_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      rptr_q   <= '0;
      cnt_q    <= '0;
      paused_q <= 1'b0;
      valid_q  <= 1'b0;
      acc_q    <= 1'b0;
      ntf_q    <= 1'b0;
      rvld_q   <= 1'b0;
    end else begin
      wptr_q   <= wptr_d;
      rptr_q   <= rptr_d;
      cnt_q    <= cnt_d;
      paused_q <= paused_d;
      valid_q  <= accept;
      acc_q    <= acc_d;
      ntf_q    <= ntf_d;
      rvld_q   <= rvld_d;
    end
  end

  urx_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wptr_q),
    .wdata_i (item_i.rx_byte),
    .re_i    (mem_re),
    .raddr_i (rptr_q),
    .rdata_o (rdata)
  );

  assign valid_o             = valid_q;
  assign result_o.accepted   = acc_q;
  assign result_o.notify     = ntf_q;
  assign result_o.read_valid = rvld_q;
  assign result_o.read_byte  = rvld_q ? rdata : 8'h00;
  assign result_o.fill_count = urx_pkg::FillWidth'(cnt_q);
  assign result_o.paused     = paused_q;

endmodule
`default_nettype wire
